>>> rtl/fcf_pkg.sv
// Package with the item types and fixed constants of the FIR convolution filter.
`timescale 1ns / 1ps

package fcf_pkg;

    // Field widths fixed by the item format.
    localparam int DATA_WIDTH  = 16;
    localparam int INDEX_WIDTH = 10;
    localparam int COUNT_WIDTH = 11;

    // Operation codes carried by an input request.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Input request: a sample to filter or a coefficient to load.
    typedef struct packed {
        logic                           opcode;
        logic signed [DATA_WIDTH-1:0]   sample_in;
        logic        [INDEX_WIDTH-1:0]  tap_index;
        logic signed [DATA_WIDTH-1:0]   coefficient;
    } in_item_t;

    // Result request: one filtered sample.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]   sample_out;
        logic                           saturated;
    } out_item_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic start;
        logic data_valid;
    } mac_ctrl_t;

endpackage

>>> rtl/fir_convolution_filter.sv
// Direct-form FIR filter: one shared multiply-accumulate walks the taps of a circular delay line.
// A sample request walks the taps in ST_RUN, waits in ST_DRAIN for the MAC to empty, then hands
// its result over in ST_OUT; a coefficient request or a sample with tap_count zero skips the walk.
// No request is accepted until a sample's result is out, since the MAC and memory port are single.
// Reset and every tap_count write start a clearing pass over MAX_TAPS entries of both memories,
// during which no request is accepted.
`timescale 1ns / 1ps

module fir_convolution_filter #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [fcf_pkg::COUNT_WIDTH-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  fcf_pkg::in_item_t                      s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output fcf_pkg::out_item_t                     m_item
);
    import fcf_pkg::*;

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 2 * DATA_WIDTH + NW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_TAPS - 1);

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] tap_count_reg, tap_count_next;
    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] tap_idx_reg, tap_idx_next;
    logic [AW-1:0] dly_ptr_reg, dly_ptr_next;
    logic          rd_vld_reg;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_item_reg, m_item_next;

    logic          accept;
    logic          is_coef;
    logic          no_taps;
    logic [AW-1:0] last_tap;
    logic          idx_in_range;
    logic          out_free;

    mac_ctrl_t     mac_ctrl;
    logic          mac_busy;
    out_item_t     mac_result;

    logic                         wgt_we, dly_we;
    logic [AW-1:0]                wgt_waddr, dly_waddr;
    logic signed [DATA_WIDTH-1:0] wgt_wdata, dly_wdata;
    logic signed [DATA_WIDTH-1:0] wgt_rdata, dly_rdata;

    // Handshake and decode of the incoming request.
    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign is_coef      = (s_item.opcode == OP_COEF);
    assign no_taps      = (tap_count_reg == '0);
    assign last_tap     = AW'(tap_count_reg - 1'b1);
    assign idx_in_range = (32'(s_item.tap_index) < 32'(tap_count_reg));

    // Memory write ports: the clearing pass has them to itself.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wgt_we    = 1'b1;
            wgt_waddr = clr_addr_reg;
            wgt_wdata = '0;
            dly_we    = 1'b1;
            dly_waddr = clr_addr_reg;
            dly_wdata = '0;
        end else begin
            wgt_we    = accept && is_coef && idx_in_range;
            wgt_waddr = AW'(s_item.tap_index);
            wgt_wdata = s_item.coefficient;
            dly_we    = accept && !is_coef && !no_taps;
            dly_waddr = wr_pos_reg;
            dly_wdata = s_item.sample_in;
        end
    end

    // Sequencer.
    always_comb begin
        state_next          = state_reg;
        tap_count_next      = tap_count_reg;
        wr_pos_next         = wr_pos_reg;
        clr_addr_next       = clr_addr_reg;
        tap_idx_next        = tap_idx_reg;
        dly_ptr_next        = dly_ptr_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_item_next         = m_item_reg;
        mac_ctrl.start      = 1'b0;
        mac_ctrl.data_valid = rd_vld_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && !is_coef) begin
                    if (no_taps) begin
                        m_item_next.sample_out = s_item.sample_in;
                        m_item_next.saturated  = 1'b0;
                        m_valid_next           = 1'b1;
                    end else begin
                        mac_ctrl.start = 1'b1;
                        tap_idx_next   = '0;
                        dly_ptr_next   = wr_pos_reg;
                        wr_pos_next    = (wr_pos_reg == '0) ? last_tap : wr_pos_reg - 1'b1;
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // One tap read per cycle; the delay pointer wraps at the tap count.
                tap_idx_next = tap_idx_reg + 1'b1;
                dly_ptr_next = (dly_ptr_reg == last_tap) ? '0 : dly_ptr_reg + 1'b1;
                if (tap_idx_reg == last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_item_next  = mac_result;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A tap count write clamps the value and restarts the clearing pass.
        if (cfg_we) begin
            if (32'(cfg_wdata) > MAX_TAPS) begin
                tap_count_next = NW'(MAX_TAPS);
            end else begin
                tap_count_next = NW'(cfg_wdata);
            end
            wr_pos_next   = '0;
            clr_addr_next = '0;
            state_next    = ST_CLEAR;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tap_count_reg <= '0;
            wr_pos_reg    <= '0;
            clr_addr_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
            wr_pos_reg    <= wr_pos_next;
            clr_addr_reg  <= clr_addr_next;
            rd_vld_reg    <= (state_reg == ST_RUN);
            m_valid_reg   <= m_valid_next;
        end
    end

    // Address and result payload registers.
    always_ff @(posedge aclk) begin
        tap_idx_reg <= tap_idx_next;
        dly_ptr_reg <= dly_ptr_next;
        m_item_reg  <= m_item_next;
    end

    fcf_store #(
        .AW (AW)
    ) u_store (
        .aclk      (aclk),
        .wgt_we    (wgt_we),
        .wgt_waddr (wgt_waddr),
        .wgt_wdata (wgt_wdata),
        .wgt_raddr (tap_idx_reg),
        .wgt_rdata (wgt_rdata),
        .dly_we    (dly_we),
        .dly_waddr (dly_waddr),
        .dly_wdata (dly_wdata),
        .dly_raddr (dly_ptr_reg),
        .dly_rdata (dly_rdata)
    );

    fcf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .weight  (wgt_rdata),
        .sample  (dly_rdata),
        .busy    (mac_busy),
        .result  (mac_result)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTH
    // The tap walk only runs with a non-zero tap count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (tap_count_reg != '0))
        else $error("tap walk running with no taps");

    // Read addresses stay inside the active taps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |->
            (32'(tap_idx_reg) < 32'(tap_count_reg)) && (32'(dly_ptr_reg) < 32'(tap_count_reg)))
        else $error("tap read address beyond tap count");

    // The write position never leaves the active part of the delay line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tap_count_reg != '0) |-> (32'(wr_pos_reg) < 32'(tap_count_reg)))
        else $error("write position beyond tap count");

    // A tap count write always starts a clearing pass from the first entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (state_reg == ST_CLEAR) && (clr_addr_reg == '0) && !s_ready)
        else $error("tap count write did not restart clearing");
`endif

endmodule

>>> rtl/fcf_store.sv
// Coefficient and delay line memories, each with one write and one registered read port.
`timescale 1ns / 1ps

module fcf_store #(
    parameter int AW = 10
) (
    input  logic                                 aclk,
    input  logic                                 wgt_we,
    input  logic [AW-1:0]                        wgt_waddr,
    input  logic signed [fcf_pkg::DATA_WIDTH-1:0] wgt_wdata,
    input  logic [AW-1:0]                        wgt_raddr,
    output logic signed [fcf_pkg::DATA_WIDTH-1:0] wgt_rdata,
    input  logic                                 dly_we,
    input  logic [AW-1:0]                        dly_waddr,
    input  logic signed [fcf_pkg::DATA_WIDTH-1:0] dly_wdata,
    input  logic [AW-1:0]                        dly_raddr,
    output logic signed [fcf_pkg::DATA_WIDTH-1:0] dly_rdata
);
    import fcf_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic signed [DATA_WIDTH-1:0] wgt_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] dly_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] wgt_rdata_reg;
    logic signed [DATA_WIDTH-1:0] dly_rdata_reg;

    // Tap weight memory.
    always_ff @(posedge aclk) begin
        if (wgt_we) begin
            wgt_mem[wgt_waddr] <= wgt_wdata;
        end
        wgt_rdata_reg <= wgt_mem[wgt_raddr];
    end

    // Circular delay line memory.
    always_ff @(posedge aclk) begin
        if (dly_we) begin
            dly_mem[dly_waddr] <= dly_wdata;
        end
        dly_rdata_reg <= dly_mem[dly_raddr];
    end

    assign wgt_rdata = wgt_rdata_reg;
    assign dly_rdata = dly_rdata_reg;

endmodule

>>> rtl/fcf_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
`timescale 1ns / 1ps

module fcf_mac #(
    parameter int ACC_W = 43
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fcf_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [fcf_pkg::DATA_WIDTH-1:0] weight,
    input  logic signed [fcf_pkg::DATA_WIDTH-1:0] sample,
    output logic                                  busy,
    output fcf_pkg::out_item_t                    result
);
    import fcf_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam logic signed [ACC_W-1:0] RND_BIAS =
        {{(ACC_W-1){1'b0}}, 1'b1} << (DATA_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;

    // Product register between the multiplier and the accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.data_valid;
        end
        if (ctrl.data_valid) begin
            prod_reg <= weight * sample;
        end
    end

    // Accumulator, cleared when a new sample starts.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.start) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Round half up, drop the fraction bits and clip to the sample range.
    always_comb begin
        rnd     = acc_reg + RND_BIAS;
        shifted = rnd >>> (DATA_WIDTH - 1);
        if (shifted > SAT_HI) begin
            result.sample_out = SAT_HI[DATA_WIDTH-1:0];
            result.saturated  = 1'b1;
        end else if (shifted < SAT_LO) begin
            result.sample_out = SAT_LO[DATA_WIDTH-1:0];
            result.saturated  = 1'b1;
        end else begin
            result.sample_out = shifted[DATA_WIDTH-1:0];
            result.saturated  = 1'b0;
        end
    end

    assign busy = prod_vld_reg;

endmodule

>>> test/tb_fir_convolution_filter.sv
// Self-checking testbench for the FIR convolution filter, with a built-in filter predictor.
`timescale 1ns / 1ps

module tb_fir_convolution_filter;

    import fcf_pkg::*;

    localparam int MAX_TAPS = 1024;

    // Clock, reset and block inputs, all at known values from time zero.
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [COUNT_WIDTH-1:0] cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;

    // Predictor state: a private copy of the filter memories and settings.
    logic signed [DATA_WIDTH-1:0] model_history [MAX_TAPS];
    logic signed [DATA_WIDTH-1:0] model_weights [MAX_TAPS];
    int unsigned                  model_taps;
    int unsigned                  model_wpos;

    out_item_t pending_outputs [$];
    int        mismatch_count = 0;
    int        ready_hold     = 0;
    bit        no_idle        = 1'b0;

    fir_convolution_filter #(
        .MAX_TAPS (MAX_TAPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs.
    initial begin
        #(40_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Clears the predictor's delay line, weights and write pointer.
    function automatic void clear_model();
        int unsigned k;
        for (k = 0; k < MAX_TAPS; k++) begin
            model_history[k] = '0;
            model_weights[k] = '0;
        end
        model_wpos = 0;
    endfunction

    // Applies one accepted request to the predictor and queues any filtered sample it yields.
    function automatic void model_filter(input in_item_t req);
        longint      acc;
        longint      sum;
        int unsigned k;
        int unsigned j;
        out_item_t   res;
        if (req.opcode == OP_COEF) begin
            if (req.tap_index < model_taps) begin
                model_weights[req.tap_index] = req.coefficient;
            end
            return;
        end
        res.saturated = 1'b0;
        if (model_taps == 0) begin
            res.sample_out = req.sample_in;
        end else begin
            if (model_wpos >= model_taps) begin
                model_wpos = 0;
            end
            model_history[model_wpos] = req.sample_in;
            acc = 0;
            for (k = 0; k < model_taps; k++) begin
                j = model_wpos + k;
                if (j >= model_taps) begin
                    j -= model_taps;
                end
                acc += longint'(model_weights[k]) * longint'(model_history[j]);
            end
            model_wpos = (model_wpos == 0) ? model_taps - 1 : model_wpos - 1;
            // Round half up, then scale back to Q15 and clip.
            sum = (acc + 64'sd16384) >>> (DATA_WIDTH - 1);
            if (sum > 32767) begin
                sum = 32767;
                res.saturated = 1'b1;
            end else if (sum < -32768) begin
                sum = -32768;
                res.saturated = 1'b1;
            end
            res.sample_out = sum[DATA_WIDTH-1:0];
        end
        pending_outputs.push_back(res);
    endfunction

    // A Q15 value biased towards the extremes and small magnitudes.
    function automatic logic signed [DATA_WIDTH-1:0] rand_q15();
        logic signed [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            1: begin
                v = $signed(16'($urandom)) >>> $urandom_range(4, 12);
            end
            default: begin
                v = 16'($urandom);
            end
        endcase
        return v;
    endfunction

    // Sends a request after a random gap, none with no_idle, and updates the predictor on acceptance.
    // Valid is left high so that a following request can go out back to back.
    task automatic send_request(input in_item_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        model_filter(req);
    endtask

    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] value);
        in_item_t req;
        req             = '0;
        req.opcode      = OP_SAMPLE;
        req.sample_in   = value;
        req.tap_index   = 10'($urandom);
        req.coefficient = 16'($urandom);
        send_request(req);
    endtask

    task automatic send_coef(input logic [INDEX_WIDTH-1:0] idx,
                             input logic signed [DATA_WIDTH-1:0] value);
        in_item_t req;
        req             = '0;
        req.opcode      = OP_COEF;
        req.sample_in   = 16'($urandom);
        req.tap_index   = idx;
        req.coefficient = value;
        send_request(req);
    endtask

    // Stops sending and waits until every filtered sample has come back and
    // any trailing coefficient request has settled.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Writes tap_count while the block is idle; the write also clears both memories.
    task automatic set_tap_count(input logic [COUNT_WIDTH-1:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        model_taps = (value > MAX_TAPS) ? MAX_TAPS : value;
        clear_model();
    endtask

    // Result side: random back-pressure, and each result checked against the oldest expectation.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: sample_out %0d saturated %0d",
                       m_item.sample_out, m_item.saturated);
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_item.sample_out !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, m_item.sample_out);
                    mismatch_count++;
                end
                if (m_item.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, m_item.saturated);
                    mismatch_count++;
                end
            end
            ready_hold = no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    // With the reset tap count of zero, samples come back untouched and coefficients are dropped.
    task automatic test_pass_through();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_coef(10'd0, 16'sh1234);
        send_sample(16'sh0000);
    endtask

    // One tap: extreme products, rounding of exact halves, and an index past the end.
    task automatic test_single_tap_rounding();
        set_tap_count(11'd1);
        send_coef(10'd0, 16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_coef(10'd0, 16'sh0001);
        send_sample(16'sh4000);
        send_sample(-16'sh4000);
        send_coef(10'd1, 16'sh7FFF);
    endtask

    // Three full-scale taps drive the sum past both ends of the range, back to back.
    task automatic test_saturation();
        int k;
        no_idle = 1'b1;
        set_tap_count(11'd3);
        for (k = 0; k < 3; k++) begin
            send_coef(INDEX_WIDTH'(k), 16'sh7FFF);
        end
        send_coef(10'h3FF, 16'sh8000);
        for (k = 0; k < 3; k++) begin
            send_sample(16'sh7FFF);
        end
        for (k = 0; k < 3; k++) begin
            send_sample(16'sh8000);
        end
        no_idle = 1'b0;
    endtask

    // An over-range tap count is clamped to the maximum; both ends of the weight store are used.
    task automatic test_clamped_tap_count();
        set_tap_count(11'h7FF);
        send_coef(10'd0, 16'sh7FFF);
        send_coef(10'h3FF, 16'sh8000);
        send_coef(10'($urandom_range(1, 1022)), rand_q15());
        send_sample(16'sh8000);
        send_sample(rand_q15());
        send_sample(16'sh7FFF);
    endtask

    // Several tap counts in turn: a full weight load, then mostly samples with some reloads.
    task automatic test_random_settings();
        int unsigned counts [10];
        int unsigned n;
        int          p;
        int          k;
        in_item_t    req;
        counts = '{2, 5, 1, 16, 0, 37, 3, 64, 8, 0};
        counts[9] = $urandom_range(1, 48);
        for (p = 0; p < 10; p++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_tap_count(COUNT_WIDTH'(counts[p]));
            n = model_taps;
            for (k = 0; k < n; k++) begin
                send_coef(INDEX_WIDTH'(k), rand_q15());
            end
            for (k = 0; k < 40; k++) begin
                // Once at least, let the filter run dry mid-stream.
                if (k == 20 && (p == 0 || $urandom_range(0, 2) == 0)) begin
                    wait_idle();
                end
                req.opcode      = ($urandom_range(0, 9) < 8) ? OP_SAMPLE : OP_COEF;
                req.sample_in   = rand_q15();
                req.coefficient = rand_q15();
                if (n > 0 && $urandom_range(0, 4) != 0) begin
                    req.tap_index = INDEX_WIDTH'($urandom_range(0, n - 1));
                end else begin
                    req.tap_index = 10'($urandom);
                end
                send_request(req);
            end
        end
        no_idle = 1'b0;
    endtask

    // Reset, the tests in turn, then drain and report.
    initial begin
        model_taps = 0;
        clear_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_pass_through();
        test_single_tap_rounding();
        test_saturation();
        test_clamped_tap_count();
        test_random_settings();

        wait_idle();
        repeat (model_taps + 8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/fcf_pkg.sv
rtl/fcf_store.sv
rtl/fcf_mac.sv
rtl/fir_convolution_filter.sv
test/tb_fir_convolution_filter.sv
